@@ design/sha1s_pkg.sv @@
// shared types, constants and round functions for the sha-1 stream hasher
package sha1s_pkg;

   // queue depths used as defaults on the top level
   localparam int CMD_DEPTH_DEF = 4;
   localparam int RSP_DEPTH_DEF = 8;

   // command kinds passed from the front to the back
   localparam logic [1:0] CMD_BYTE = 2'd0;
   localparam logic [1:0] CMD_LAST = 2'd1;
   localparam logic [1:0] CMD_END  = 2'd2;

   // last digest word index and last round number
   localparam logic [2:0] LAST_WORD  = 3'd4;
   localparam logic [6:0] LAST_ROUND = 7'd79;

   // pad byte and block offsets
   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] FILL_FULL  = 6'd63;
   localparam logic [5:0] FILL_LEN   = 6'd55;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } rsp_type;

   typedef logic [31:0] word_type;

   // initial chaining value
   localparam word_type H_INIT [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   function automatic word_type rotl(input word_type v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   // round constant by round number
   function automatic word_type round_k(input logic [6:0] r);
      if (r < 7'd20)      round_k = 32'h5A827999;
      else if (r < 7'd40) round_k = 32'h6ED9EBA1;
      else if (r < 7'd60) round_k = 32'h8F1BBCDC;
      else                round_k = 32'hCA62C1D6;
   endfunction

   // round boolean function by round number
   function automatic word_type round_f(input logic [6:0] r, input word_type b,
                                        input word_type c, input word_type d);
      if (r < 7'd20)                     round_f = (b & c) | (~b & d);
      else if (r < 7'd40 || r >= 7'd60) round_f = b ^ c ^ d;
      else                               round_f = (b & c) | (b & d) | (c & d);
   endfunction

endpackage

@@ design/sha1s_fifo.sv @@
// small register queue with push/full and pop/empty sides
module sha1s_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = store_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ design/sha1s_front.sv @@
// input side: classifies each transfer and queues it as a command
module sha1s_front import sha1s_pkg::*; #(
   parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   input  logic       req_end_only,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_pop
);

   cmd_type                 cmd_w;
   logic [$bits(cmd_type)-1:0] cmd_q;
   logic                    cmd_empty;

   // end-only wins over the last-byte flag
   always_comb begin
      cmd_w.data = req_data_byte;
      if (req_end_only) begin
         cmd_w.kind = CMD_END;
      end else if (req_is_last) begin
         cmd_w.kind = CMD_LAST;
      end else begin
         cmd_w.kind = CMD_BYTE;
      end
   end

   sha1s_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (cmd_w),
      .full  (full),
      .pop   (cmd_pop),
      .rdata (cmd_q),
      .empty (cmd_empty)
   );

   assign cmd       = cmd_q;
   assign cmd_valid = ~cmd_empty;

endmodule

@@ design/sha1s_core.sv @@
// back side: block packing, padding, 80-round compression and digest output
module sha1s_core import sha1s_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_push,
   output rsp_type rsp_data,
   input  logic    rsp_full
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ROUND  = 3'd1;
   localparam logic [2:0] S_UPDATE = 3'd2;
   localparam logic [2:0] S_PAD    = 3'd3;
   localparam logic [2:0] S_LEN    = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;

   localparam logic [1:0] FIN_NONE = 2'd0;
   localparam logic [1:0] FIN_PAD  = 2'd1;
   localparam logic [1:0] FIN_EMIT = 2'd2;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  fin_ff, fin_in;
   logic        pad_done_ff, pad_done_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] total_ff, total_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [2:0]  idx_ff, idx_in;
   word_type    h_ff [5];
   word_type    h_in [5];
   word_type    work_ff [5];
   word_type    work_in [5];
   word_type    line_ff [16];
   word_type    line_in [16];
   logic [23:0] acc_ff, acc_in;

   logic        put_en, shift_en, line_clear, start;
   logic [7:0]  put_val;
   word_type    shift_word;
   word_type    sched_word, temp;
   logic [63:0] bit_len;

   // round datapath and message schedule tap
   assign sched_word = rotl(line_ff[13] ^ line_ff[8] ^ line_ff[2] ^ line_ff[0], 1);
   assign temp = rotl(work_ff[0], 5)
               + round_f(rnd_ff, work_ff[1], work_ff[2], work_ff[3])
               + work_ff[4] + line_ff[0] + round_k(rnd_ff);
   assign bit_len = {total_ff, 3'b000};

   assign rsp_data.word  = h_ff[idx_ff];
   assign rsp_data.index = idx_ff;
   assign rsp_data.last  = (idx_ff == LAST_WORD);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      fin_in      = fin_ff;
      pad_done_in = pad_done_ff;
      fill_in     = fill_ff;
      total_in    = total_ff;
      rnd_in      = rnd_ff;
      idx_in      = idx_ff;
      h_in        = h_ff;
      work_in     = work_ff;
      line_in     = line_ff;
      acc_in      = acc_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      put_en      = 1'b0;
      put_val     = 8'h00;
      shift_en    = 1'b0;
      shift_word  = '0;
      line_clear  = 1'b0;
      start       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               pad_done_in = 1'b0;
               if (cmd.kind == CMD_END) begin
                  fin_in   = FIN_PAD;
                  state_in = S_PAD;
               end else begin
                  put_en   = 1'b1;
                  put_val  = cmd.data;
                  total_in = total_ff + 61'd1;
                  fin_in   = (cmd.kind == CMD_LAST) ? FIN_PAD : FIN_NONE;
                  if (fill_ff == FILL_FULL) begin
                     start = 1'b1;
                  end else if (cmd.kind == CMD_LAST) begin
                     state_in = S_PAD;
                  end
               end
            end
         end
         S_ROUND: begin
            work_in[0] = temp;
            work_in[1] = work_ff[0];
            work_in[2] = rotl(work_ff[1], 30);
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3];
            shift_en   = 1'b1;
            shift_word = sched_word;
            rnd_in     = rnd_ff + 7'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            for (int i = 0; i < 5; i++) begin
               h_in[i] = h_ff[i] + work_ff[i];
            end
            line_clear = 1'b1;
            fill_in    = '0;
            case (fin_ff)
               FIN_PAD:  state_in = S_PAD;
               FIN_EMIT: state_in = S_EMIT;
               default:  state_in = S_IDLE;
            endcase
         end
         S_PAD: begin
            put_en      = 1'b1;
            put_val     = pad_done_ff ? 8'h00 : PAD_BYTE;
            pad_done_in = 1'b1;
            if (fill_ff == FILL_FULL) begin
               start = 1'b1;
            end else if (fill_ff == FILL_LEN) begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            shift_en   = 1'b1;
            shift_word = fill_ff[2] ? bit_len[31:0] : bit_len[63:32];
            fill_in    = fill_ff + 6'd4;
            if (fill_ff[2]) begin
               fin_in = FIN_EMIT;
               start  = 1'b1;
            end
         end
         S_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               idx_in   = idx_ff + 3'd1;
               if (idx_ff == LAST_WORD) begin
                  idx_in   = '0;
                  h_in     = H_INIT;
                  total_in = '0;
                  fin_in   = FIN_NONE;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // byte insertion into the word accumulator
      if (put_en) begin
         acc_in  = {acc_ff[15:0], put_val};
         fill_in = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'd3) begin
            shift_en   = 1'b1;
            shift_word = {acc_ff, put_val};
         end
      end

      // word line shifts toward index zero
      if (shift_en) begin
         for (int i = 0; i < 15; i++) begin
            line_in[i] = line_ff[i + 1];
         end
         line_in[15] = shift_word;
      end
      if (line_clear) begin
         for (int i = 0; i < 16; i++) begin
            line_in[i] = '0;
         end
      end

      // load working variables at the start of a compression
      if (start) begin
         work_in  = h_ff;
         rnd_in   = '0;
         state_in = S_ROUND;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fin_ff      <= FIN_NONE;
         pad_done_ff <= 1'b0;
         fill_ff     <= '0;
         total_ff    <= '0;
         rnd_ff      <= '0;
         idx_ff      <= '0;
         h_ff        <= H_INIT;
         for (int i = 0; i < 16; i++) begin
            line_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         fin_ff      <= fin_in;
         pad_done_ff <= pad_done_in;
         fill_ff     <= fill_in;
         total_ff    <= total_in;
         rnd_ff      <= rnd_in;
         idx_ff      <= idx_in;
         h_ff        <= h_in;
         line_ff     <= line_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      acc_ff  <= acc_in;
   end

endmodule

@@ design/sha1_stream_hasher.sv @@
// sha-1 stream hasher: byte in, five digest words out per message
// the back end takes in one message byte at a time; every 64th byte starts a compression
// (80 rounds of the single shared round unit plus one chaining update)
// closing a message costs up to 64 pad bytes, two length words, one or two
// compressions and the output of the five digest words
// synchronous active-high reset empties both queues and loads the initial hash value
module sha1_stream_hasher import sha1s_pkg::*; #(
   parameter int CMD_DEPTH = CMD_DEPTH_DEF,
   parameter int RSP_DEPTH = RSP_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_last,
   input  logic        req_end_only,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_last
);

   logic                       cmd_valid, cmd_pop;
   cmd_type                    cmd;
   logic                       rsp_push, rsp_full;
   rsp_type                    rsp_data, rsp_q;
   logic [$bits(rsp_type)-1:0] rsp_rdata;

   // front: classify and queue commands
   sha1s_front #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data_byte (req_data_byte),
      .req_is_last   (req_is_last),
      .req_end_only  (req_end_only),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   // back: packing, padding and compression
   sha1s_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data),
      .rsp_full  (rsp_full)
   );

   // result queue
   sha1s_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_data),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_rdata),
      .empty (empty)
   );

   assign rsp_q           = rsp_rdata;
   assign rsp_digest_word = rsp_q.word;
   assign rsp_word_index  = rsp_q.index;
   assign rsp_digest_last = rsp_q.last;

   // the result queue comes out of reset empty and the command queue not full
   a_reset_empty: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // last flag marks exactly the fifth word
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_digest_last == (rsp_word_index == LAST_WORD)))
      else $error("digest_last does not match word_index");

   // digest words leave in index order
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && rsp_word_index != LAST_WORD) |=>
      (empty || rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word out of order");

endmodule
